// File: rtl/cqr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cqr_pkg
// Shared constants and types for the compacting tag queue.
// ----------------------------------------------------------------------------
package cqr_pkg;

  localparam int DEPTH     = 128;
  localparam int TAG_CHARS = 6;
  localparam int TAG_W     = 8 * TAG_CHARS;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// File: rtl/cqr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cqr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cqr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/compacting_queue_remove_at_index.sv
`default_nettype none
// append and rejected items go through S_DONE to the output reg, a read via S_FETCH first
// remove at position p: S_FETCH, then S_SHIFT per later entry, one entry moved per cycle
// the shift sweep is bound by the single read and write port of the entry ram
// one item at a time: the next is accepted as the result enters the output reg
// reset clears the count and the handshake state; entries are not cleared
// ----------------------------------------------------------------------------
// compacting_queue_remove_at_index
// Ordered tag queue with append, pop front, remove and read at a position.
// ----------------------------------------------------------------------------
module compacting_queue_remove_at_index
  import cqr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  operation,
  input  wire logic [47:0] tag_value,
  input  wire logic [6:0]  position,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [7:0]       count,
  output logic [47:0]      read_value
);

  state_t              state, state_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [ADDR_W-1:0]   idx;
  logic                is_remove;
  status_t             res_status;
  logic [7:0]          res_count;
  logic [47:0]         res_value;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [TAG_W-1:0]    ram_wdata, ram_rdata;

  op_t                 op_in;
  status_t             acc_status;
  logic [ADDR_W-1:0]   pos_addr, cnt_addr;
  logic                accept, out_free;

  assign op_in    = op_t'(operation);
  assign pos_addr = ADDR_W'(position);
  assign cnt_addr = ADDR_W'(cnt);
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    acc_status = ST_OK;
    cnt_next   = cnt;
    unique case (op_in)
      OP_APPEND: begin
        if (cnt == CNT_W'(DEPTH)) acc_status = ST_FULL;
        else cnt_next = cnt + CNT_W'(1);
      end
      OP_POP: begin
        if (cnt == '0) acc_status = ST_EMPTY;
        else cnt_next = cnt - CNT_W'(1);
      end
      OP_REMOVE: begin
        if (cnt == '0) acc_status = ST_EMPTY;
        else if (32'(position) >= 32'(cnt)) acc_status = ST_RANGE;
        else cnt_next = cnt - CNT_W'(1);
      end
      OP_READ: begin
        if (32'(position) >= 32'(cnt)) acc_status = ST_RANGE;
      end
      default: acc_status = ST_OK;
    endcase
  end

  // cnt already holds the count after removal during fetch and shift
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = cnt_addr;
    ram_wdata  = tag_value[TAG_W-1:0];
    ram_re     = 1'b0;
    ram_raddr  = pos_addr;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (acc_status != ST_OK) begin
            state_next = S_DONE;
          end else if (op_in == OP_APPEND) begin
            ram_we     = 1'b1;
            state_next = S_DONE;
          end else begin
            ram_re     = 1'b1;
            ram_raddr  = (op_in == OP_POP) ? '0 : pos_addr;
            state_next = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        if (is_remove && (32'(idx) < 32'(cnt))) begin
          ram_re     = 1'b1;
          ram_raddr  = idx + ADDR_W'(1);
          state_next = S_SHIFT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = ram_rdata;
        if ((32'(idx) + 32'd1) < 32'(cnt)) begin
          ram_re    = 1'b1;
          ram_raddr = idx + ADDR_W'(2);
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_DONE) && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cnt        <= cnt_next;
            is_remove  <= (op_in != OP_READ);
            idx        <= (op_in == OP_POP) ? '0 : pos_addr;
            res_status <= acc_status;
            res_count  <= 8'(cnt_next);
            res_value  <= '0;
          end
        end
        S_FETCH: begin
          res_value <= 48'(ram_rdata);
        end
        S_SHIFT: begin
          idx <= idx + ADDR_W'(1);
        end
        S_DONE: begin
          if (out_free) begin
            status     <= res_status;
            count      <= res_count;
            read_value <= res_value;
          end
        end
        default: ;
      endcase
    end
  end

  cqr_ram #(
    .WIDTH (TAG_W),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

// File: rtl/cqr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cqr_checker
// Port-level assertions for the compacting tag queue, bound to the top level.
// ----------------------------------------------------------------------------
module cqr_checker
  import cqr_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [7:0]  count,
  input wire logic [47:0] read_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(count)
      && $stable(read_value))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in flight");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> count == 8'(DEPTH))
    else $error("full status without a full queue");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EMPTY) |-> count == 8'd0)
    else $error("empty status with entries present");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> read_value == 48'd0)
    else $error("rejected item returned data");

endmodule

bind compacting_queue_remove_at_index cqr_checker u_cqr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status),
  .count      (count),
  .read_value (read_value)
);
`default_nettype wire
